// ===== src/tmx_pkg.sv =====
package tmx_pkg;

  // Default sizing of the trie
  localparam int KEY_BITS_DEF   = 32;
  localparam int NODE_COUNT_DEF = 4096;

  // Fixed port width of the key and result fields
  localparam int VALUE_W = 32;

  // Item kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_ALLOC
  } tmx_state_t;

  typedef struct packed {
    logic [VALUE_W-1:0] best_xor;
    logic               empty_res;
    logic               pool_full;
  } tmx_result_t;

endpackage

// ===== src/tmx_node_mem.sv =====
module tmx_node_mem #(
  parameter int NODE_COUNT = tmx_pkg::NODE_COUNT_DEF,
  localparam int IDX_W = $clog2(NODE_COUNT)
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [IDX_W-1:0]       waddr,
  input  logic [1:0][IDX_W-1:0]  wdata,
  input  logic                   re,
  input  logic [IDX_W-1:0]       raddr,
  output logic [1:0][IDX_W-1:0]  rdata
);

  // One entry per node: child link for bit 0 and for bit 1
  logic [1:0][IDX_W-1:0] mem [NODE_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/tmx_seq.sv =====
module tmx_seq #(
  parameter int KEY_BITS   = tmx_pkg::KEY_BITS_DEF,
  parameter int NODE_COUNT = tmx_pkg::NODE_COUNT_DEF,
  localparam int IDX_W = $clog2(NODE_COUNT),
  localparam int LVL_W = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1,
  localparam int CNT_W = $clog2(NODE_COUNT + 1),
  localparam int SUM_W = CNT_W + 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          kind,
  input  logic [tmx_pkg::VALUE_W-1:0]   value,
  output logic                          busy,
  output logic                          fin,
  output tmx_pkg::tmx_result_t          res,
  output logic                          mem_we,
  output logic [IDX_W-1:0]              mem_waddr,
  output logic [1:0][IDX_W-1:0]         mem_wdata,
  output logic                          mem_re,
  output logic [IDX_W-1:0]              mem_raddr,
  input  logic [1:0][IDX_W-1:0]         mem_rdata
);

  tmx_pkg::tmx_state_t state, state_next;

  logic [LVL_W-1:0]    lvl, lvl_next;
  logic [IDX_W-1:0]    cur, cur_next;
  logic [KEY_BITS-1:0] key, key_next;
  logic                kind_q, kind_q_next;
  logic [KEY_BITS-1:0] acc, acc_next;
  logic [CNT_W-1:0]    nf, nf_next;
  logic                has_values, has_values_next;
  logic                root_ok, root_ok_next;

  logic [1:0][IDX_W-1:0] links;
  logic                  bit_cur, bit_dn;
  logic [IDX_W-1:0]      same, opp, nf_idx;
  logic                  lvl_zero, need_over;
  logic [LVL_W-1:0]      lvl_dn;
  logic [KEY_BITS-1:0]   acc_new;

  // Root entry reads as empty until first written after reset
  assign links    = (cur == '0 && !root_ok) ? '0 : mem_rdata;
  assign bit_cur  = key[lvl];
  assign same     = links[bit_cur];
  assign opp      = links[~bit_cur];
  assign lvl_zero = (lvl == '0);
  assign lvl_dn   = lvl - LVL_W'(1);
  assign bit_dn   = key[lvl_dn];
  assign nf_idx   = nf[IDX_W-1:0];
  assign need_over = (SUM_W'(nf) + SUM_W'(lvl) + SUM_W'(1)) > SUM_W'(NODE_COUNT);
  assign acc_new  = (opp != '0) ? (acc | (KEY_BITS'(1) << lvl)) : acc;
  assign busy     = (state != tmx_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tmx_pkg::ST_IDLE;
      nf         <= CNT_W'(1);
      has_values <= 1'b0;
      root_ok    <= 1'b0;
    end else begin
      state      <= state_next;
      nf         <= nf_next;
      has_values <= has_values_next;
      root_ok    <= root_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    lvl    <= lvl_next;
    cur    <= cur_next;
    key    <= key_next;
    kind_q <= kind_q_next;
    acc    <= acc_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      tmx_pkg::ST_IDLE: begin
        if (start && !(kind == tmx_pkg::KIND_QUERY && !has_values)) begin
          state_next = tmx_pkg::ST_WALK;
        end
      end
      tmx_pkg::ST_WALK: begin
        if (kind_q == tmx_pkg::KIND_QUERY) begin
          if ((opp == '0 && same == '0) || lvl_zero) begin
            state_next = tmx_pkg::ST_IDLE;
          end
        end else if (same != '0) begin
          if (lvl_zero) begin
            state_next = tmx_pkg::ST_IDLE;
          end
        end else if (need_over) begin
          state_next = tmx_pkg::ST_IDLE;
        end else begin
          state_next = tmx_pkg::ST_ALLOC;
        end
      end
      tmx_pkg::ST_ALLOC: begin
        if (lvl_zero) begin
          state_next = tmx_pkg::ST_IDLE;
        end
      end
      default: state_next = tmx_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    lvl_next        = lvl;
    cur_next        = cur;
    key_next        = key;
    kind_q_next     = kind_q;
    acc_next        = acc;
    nf_next         = nf;
    has_values_next = has_values;
    root_ok_next    = root_ok;
    mem_we          = 1'b0;
    mem_waddr       = cur;
    mem_wdata       = '0;
    mem_re          = 1'b0;
    mem_raddr       = '0;
    fin             = 1'b0;
    res             = '0;
    unique case (state)
      tmx_pkg::ST_IDLE: begin
        if (start) begin
          key_next    = value[KEY_BITS-1:0];
          kind_q_next = kind;
          lvl_next    = LVL_W'(KEY_BITS - 1);
          cur_next    = '0;
          acc_next    = '0;
          if (kind == tmx_pkg::KIND_QUERY && !has_values) begin
            fin           = 1'b1;
            res.empty_res = 1'b1;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = '0;
          end
        end
      end
      tmx_pkg::ST_WALK: begin
        if (kind_q == tmx_pkg::KIND_QUERY) begin
          // Prefer the opposite bit, fall back to the same bit
          acc_next = acc_new;
          if ((opp == '0 && same == '0) || lvl_zero) begin
            fin          = 1'b1;
            res.best_xor = tmx_pkg::VALUE_W'(acc_new);
          end else begin
            cur_next  = (opp != '0) ? opp : same;
            lvl_next  = lvl_dn;
            mem_re    = 1'b1;
            mem_raddr = (opp != '0) ? opp : same;
          end
        end else if (same != '0) begin
          if (lvl_zero) begin
            fin             = 1'b1;
            has_values_next = 1'b1;
          end else begin
            cur_next  = same;
            lvl_next  = lvl_dn;
            mem_re    = 1'b1;
            mem_raddr = same;
          end
        end else if (need_over) begin
          // Refuse the whole insert: nothing allocated
          fin           = 1'b1;
          res.pool_full = 1'b1;
        end else begin
          // Link the first new node into the existing parent
          mem_we             = 1'b1;
          mem_waddr          = cur;
          mem_wdata          = links;
          mem_wdata[bit_cur] = nf_idx;
          if (cur == '0) begin
            root_ok_next = 1'b1;
          end
          cur_next = nf_idx;
          nf_next  = nf + CNT_W'(1);
        end
      end
      tmx_pkg::ST_ALLOC: begin
        mem_we    = 1'b1;
        mem_waddr = cur;
        if (lvl_zero) begin
          // Leaf: both children empty
          fin             = 1'b1;
          has_values_next = 1'b1;
        end else begin
          mem_wdata[bit_dn] = nf_idx;
          cur_next          = nf_idx;
          nf_next           = nf + CNT_W'(1);
          lvl_next          = lvl_dn;
        end
      end
      default: ;
    endcase
  end

  a_fin_idle: assert property (@(posedge clk) disable iff (rst)
    fin |=> state == tmx_pkg::ST_IDLE)
    else $error("sequencer not idle after finishing an item");

  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    nf <= CNT_W'(NODE_COUNT))
    else $error("free node counter ran past the pool");

  a_write_ctx: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == tmx_pkg::ST_WALK || state == tmx_pkg::ST_ALLOC)
               && kind_q == tmx_pkg::KIND_INSERT)
    else $error("node write outside an insert");

  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    fin && res.pool_full |-> res.best_xor == '0 && !res.empty_res && !mem_we)
    else $error("refused insert carries other flags or writes");

  a_alloc_root: assert property (@(posedge clk) disable iff (rst)
    state == tmx_pkg::ST_ALLOC |-> cur != '0)
    else $error("allocation chain points at the root");

endmodule

// ===== src/binary_trie_max_xor_engine.sv =====
// Binary trie maximum-XOR engine. Pulse start while busy is low to hand in one
// beat: kind 0 inserts value, kind 1 asks for the largest XOR of value with any
// stored key. Exactly one result beat comes back per item, shown on best_xor,
// empty_res and pool_full for a single cycle while done is high; the receiver
// cannot stall it, so capture it on that cycle. A query walks one trie level per
// cycle through the node memory, which has a separate read and write port and a
// registered read. An insert walks existing levels the same way and then writes
// one new node per cycle. A query before any insert has been stored answers the
// next cycle with empty_res set. An insert that would need more nodes than
// remain in the NODE_COUNT pool is refused whole and answered with pool_full.
// No clearing pass is needed after reset: new nodes are zeroed as they are
// allocated and the root reads empty until first written.
module binary_trie_max_xor_engine #(
  parameter int KEY_BITS   = tmx_pkg::KEY_BITS_DEF,
  parameter int NODE_COUNT = tmx_pkg::NODE_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        kind,
  input  logic [tmx_pkg::VALUE_W-1:0] value,
  output logic                        done,
  output logic [tmx_pkg::VALUE_W-1:0] best_xor,
  output logic                        empty_res,
  output logic                        pool_full
);

  localparam int IDX_W = $clog2(NODE_COUNT);

  logic                  fin;
  tmx_pkg::tmx_result_t  res;
  logic                  mem_we, mem_re;
  logic [IDX_W-1:0]      mem_waddr, mem_raddr;
  logic [1:0][IDX_W-1:0] mem_wdata, mem_rdata;

  // Sequencer: walks the trie one level per cycle and allocates new nodes
  tmx_seq #(
    .KEY_BITS   (KEY_BITS),
    .NODE_COUNT (NODE_COUNT)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .kind      (kind),
    .value     (value),
    .busy      (busy),
    .fin       (fin),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Node pool: two child links per node
  tmx_node_mem #(
    .NODE_COUNT (NODE_COUNT)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Result register: capture the beat on fin, strobe with done
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      best_xor  <= res.best_xor;
      empty_res <= res.empty_res;
      pool_full <= res.pool_full;
    end
  end

endmodule
